// ===== hw/rtl/pkba_pkg.sv =====
// Shared types, widths and codes of the paged key/value bump allocator.
// Used by the channel interfaces and by every RTL module of the block.
package pkba_pkg;

    localparam int TAG_W     = 16;
    localparam int TOK_W     = 32;
    localparam int TOTAL_W   = 33;
    localparam int WORD_W    = 64;
    localparam int HALF_W    = 32;
    localparam int FIELD_W   = 16;
    localparam int SIZE_W    = 8;
    localparam int KINDS_W   = FIELD_W + 1;
    localparam int ELEM_W    = 2 * FIELD_W + SIZE_W;
    localparam int BLKB_W    = FIELD_W + ELEM_W;
    localparam int BLOCKS_W  = KINDS_W + TOTAL_W;
    localparam int TMP_W     = TOTAL_W + KINDS_W;
    localparam int REM_W     = FIELD_W;
    localparam int DIV_CNT_W = $clog2(TOTAL_W + 1);
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [WORD_W-1:0]  CAPACITY_RESET = 64'd1;
    localparam logic [FIELD_W-1:0] FIELD_RESET    = 16'd1;
    localparam logic [SIZE_W-1:0]  SIZE_RESET     = 8'd1;
    localparam logic [FIELD_W-1:0] TPP_RESET      = 16'd16;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_CAPACITY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_CAPACITY        = 3'd0,
        REG_LAYER_COUNT     = 3'd1,
        REG_KV_HEAD_COUNT   = 3'd2,
        REG_HEAD_WIDTH      = 3'd3,
        REG_ELEMENT_SIZE    = 3'd4,
        REG_TOKENS_PER_PAGE = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_HW     = 3'd0,
        OP_ES     = 3'd1,
        OP_BLK    = 3'd2,
        OP_TK     = 3'd3,
        OP_LOG    = 3'd4,
        OP_BLOCKS = 3'd5,
        OP_ALLOC  = 3'd6
    } mul_op_t;

    typedef enum logic [2:0] {
        BK_IDLE   = 3'd0,
        BK_ISSUE  = 3'd1,
        BK_WAIT   = 3'd2,
        BK_ROOM   = 3'd3,
        BK_CHECK  = 3'd4,
        BK_COMMIT = 3'd5
    } back_state_t;

    typedef struct packed {
        logic [WORD_W-1:0]  capacity;
        logic [FIELD_W-1:0] layer_count;
        logic [FIELD_W-1:0] kv_head_count;
        logic [FIELD_W-1:0] head_width;
        logic [SIZE_W-1:0]  element_size;
        logic [FIELD_W-1:0] tokens_per_page;
    } cfg_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [TOTAL_W-1:0] token_total;
        logic               invalid;
    } job_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [WORD_W-1:0] prod;
    } mul_rsp_t;

endpackage

// ===== hw/rtl/pkba_if.sv =====
// Request and result channel interfaces of the allocator (valid/ready).
// Depends on pkba_pkg for field widths and the status type.
interface pkba_req_if;
    logic                        valid;
    logic                        ready;
    logic [pkba_pkg::TAG_W-1:0]  request_tag;
    logic [pkba_pkg::TOK_W-1:0]  prompt_tokens;
    logic [pkba_pkg::TOK_W-1:0]  output_tokens;

    modport source (output valid, output request_tag, output prompt_tokens,
                    output output_tokens, input ready);
    modport sink   (input valid, input request_tag, input prompt_tokens,
                    input output_tokens, output ready);
endinterface

interface pkba_res_if;
    logic                          valid;
    logic                          ready;
    logic [pkba_pkg::TAG_W-1:0]    tag_out;
    pkba_pkg::status_t             status;
    logic [pkba_pkg::WORD_W-1:0]   base_offset;
    logic [pkba_pkg::WORD_W-1:0]   epoch;
    logic [pkba_pkg::TOTAL_W-1:0]  token_total;
    logic [pkba_pkg::WORD_W-1:0]   block_count;
    logic [pkba_pkg::WORD_W-1:0]   block_bytes;
    logic [pkba_pkg::WORD_W-1:0]   logical_bytes;
    logic [pkba_pkg::WORD_W-1:0]   allocated_bytes;
    logic [pkba_pkg::WORD_W-1:0]   used_total;

    modport source (output valid, output tag_out, output status, output base_offset,
                    output epoch, output token_total, output block_count,
                    output block_bytes, output logical_bytes, output allocated_bytes,
                    output used_total, input ready);
    modport sink   (input valid, input tag_out, input status, input base_offset,
                    input epoch, input token_total, input block_count,
                    input block_bytes, input logical_bytes, input allocated_bytes,
                    input used_total, output ready);
endinterface

// ===== hw/rtl/pkba_front.sv =====
// Front end: accepts requests, flags invalid ones and forms the token total.
// Depends on pkba_pkg and pkba_req_if; feeds pkba_queue.
module pkba_front (
    input  pkba_pkg::cfg_t cfg,
    pkba_req_if.sink       req,
    input  logic           q_full,
    output logic           q_push,
    output pkba_pkg::job_t q_data
);
    import pkba_pkg::*;

    logic zero_arg;

    // Any zero length or zero geometry field makes the request invalid.
    assign zero_arg = (req.prompt_tokens == '0) || (req.output_tokens == '0) ||
                      (cfg.layer_count == '0) || (cfg.kv_head_count == '0) ||
                      (cfg.head_width == '0) || (cfg.element_size == '0) ||
                      (cfg.tokens_per_page == '0);

    assign req.ready = !q_full;
    assign q_push    = req.valid && !q_full;

    always_comb
    begin
        q_data.tag         = req.request_tag;
        q_data.token_total = TOTAL_W'({1'b0, req.prompt_tokens} + {1'b0, req.output_tokens}
                             - {{TOK_W{1'b0}}, 1'b1});
        q_data.invalid     = zero_arg;
    end
endmodule

// ===== hw/rtl/pkba_queue.sv =====
// Short first-in first-out queue of classified jobs between front and back end.
// Depends on pkba_pkg for the job type.
module pkba_queue #(
    parameter int DEPTH = pkba_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pkba_pkg::job_t push_data,
    output logic           full,
    output logic           valid,
    input  logic           pop,
    output pkba_pkg::job_t pop_data
);
    import pkba_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign valid    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ===== hw/rtl/pkba_mul.sv =====
// Multi-cycle 64 x 64 multiplier with overflow flag, one 32 x 32 product a cycle.
// Depends on pkba_pkg for the request and response structs.
module pkba_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  pkba_pkg::mul_req_t req,
    output pkba_pkg::mul_rsp_t rsp
);
    import pkba_pkg::*;

    localparam int PROD_W = 2 * WORD_W;
    localparam logic [2:0] LAST_STEP = 3'd4;

    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W-1:0] pp_reg, pp_next;
    logic [1:0]        sh_reg, sh_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [HALF_W-1:0] a_half, b_half;
    logic [PROD_W-1:0] pp_ext;

    // Step k multiplies half k[0] of a by half k[1] of b; the partial product is
    // registered, and the next step adds it to the accumulator at its weight.
    assign a_half = cnt_reg[0] ? a_reg[WORD_W-1:HALF_W] : a_reg[HALF_W-1:0];
    assign b_half = cnt_reg[1] ? b_reg[WORD_W-1:HALF_W] : b_reg[HALF_W-1:0];

    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_ext = {{WORD_W{1'b0}}, pp_reg};
            2'd1:    pp_ext = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            default: pp_ext = {pp_reg, {WORD_W{1'b0}}};
        endcase
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        pp_next   = pp_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != LAST_STEP)
            begin
                pp_next = a_half * b_half;
                sh_next = {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
            end
            if (cnt_reg != '0)
            begin
                acc_next = acc_reg + pp_ext;
            end
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
    end

    always_comb
    begin
        rsp.done = done_reg;
        rsp.ovf  = (acc_reg[PROD_W-1:WORD_W] != '0);
        rsp.prod = acc_reg[WORD_W-1:0];
    end
endmodule

// ===== hw/rtl/pkba_back.sv =====
// Back end: page divider, multiply sequencer, capacity check, allocator state
// and the result register. Depends on pkba_pkg, pkba_res_if and pkba_mul.
module pkba_back (
    input  logic           clk,
    input  logic           rst_n,
    input  pkba_pkg::cfg_t cfg,
    input  logic           q_valid,
    input  pkba_pkg::job_t q_data,
    output logic           q_pop,
    pkba_res_if.source     res
);
    import pkba_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(TOTAL_W);

    back_state_t          state_reg, state_next;
    mul_op_t              op_reg, op_next, op_after;
    job_t                 job_reg, job_next;
    logic [KINDS_W-1:0]   kinds_reg, kinds_next;
    logic [TMP_W-1:0]     tmp_reg, tmp_next;
    logic [ELEM_W-1:0]    elem_reg, elem_next;
    logic [BLKB_W-1:0]    blkb_reg, blkb_next;
    logic [WORD_W-1:0]    logical_reg, logical_next;
    logic [BLOCKS_W-1:0]  blocks_reg, blocks_next;
    logic [WORD_W-1:0]    alloc_reg, alloc_next;
    logic [WORD_W-1:0]    room_reg, room_next;
    logic                 ovf_reg, ovf_next;
    status_t              status_reg, status_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [TOTAL_W-1:0]   div_quo_reg, div_quo_next;
    logic [REM_W-1:0]     div_rem_reg, div_rem_next;
    logic [WORD_W-1:0]    nfo_reg, nfo_next;
    logic [WORD_W-1:0]    seq_reg, seq_next;

    logic                 res_valid_reg, res_valid_next;
    logic [TAG_W-1:0]     res_tag_reg, res_tag_next;
    status_t              res_status_reg, res_status_next;
    logic [WORD_W-1:0]    res_base_reg, res_base_next;
    logic [WORD_W-1:0]    res_epoch_reg, res_epoch_next;
    logic [TOTAL_W-1:0]   res_tokens_reg, res_tokens_next;
    logic [WORD_W-1:0]    res_blocks_reg, res_blocks_next;
    logic [WORD_W-1:0]    res_blkb_reg, res_blkb_next;
    logic [WORD_W-1:0]    res_logical_reg, res_logical_next;
    logic [WORD_W-1:0]    res_alloc_reg, res_alloc_next;
    logic [WORD_W-1:0]    res_used_reg, res_used_next;

    mul_req_t             mul_req;
    mul_rsp_t             mul_rsp;
    logic                 div_busy;
    logic [REM_W:0]       rem_shift;
    logic                 rem_ge;
    logic [TOTAL_W-1:0]   pages;
    logic                 out_free;
    logic                 is_ok;

    pkba_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // Restoring divider for token_total / tokens_per_page, one quotient bit a
    // cycle; the dividend shifts out of the quotient register as bits come in.
    assign div_busy  = (div_cnt_reg != '0);
    assign rem_shift = {div_rem_reg, div_quo_reg[TOTAL_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, cfg.tokens_per_page});
    assign pages     = div_quo_reg + {{(TOTAL_W-1){1'b0}}, (div_rem_reg != '0)};
    assign out_free  = !res_valid_reg || res.ready;
    assign is_ok     = (status_reg == ST_OK);

    always_comb
    begin
        unique case (op_reg)
            OP_HW:     op_after = OP_ES;
            OP_ES:     op_after = OP_BLK;
            OP_BLK:    op_after = OP_TK;
            OP_TK:     op_after = OP_LOG;
            OP_LOG:    op_after = OP_BLOCKS;
            default:   op_after = OP_ALLOC;
        endcase
    end

    // Multiplier operands for each step of the sequence.
    always_comb
    begin
        mul_req.start = 1'b0;
        case (op_reg)
            OP_HW:
            begin
                mul_req.a = WORD_W'(cfg.kv_head_count);
                mul_req.b = WORD_W'(cfg.head_width);
            end
            OP_ES:
            begin
                mul_req.a = WORD_W'(tmp_reg);
                mul_req.b = WORD_W'(cfg.element_size);
            end
            OP_BLK:
            begin
                mul_req.a = WORD_W'(cfg.tokens_per_page);
                mul_req.b = WORD_W'(elem_reg);
            end
            OP_TK:
            begin
                mul_req.a = WORD_W'(job_reg.token_total);
                mul_req.b = WORD_W'(kinds_reg);
            end
            OP_LOG:
            begin
                mul_req.a = WORD_W'(tmp_reg);
                mul_req.b = WORD_W'(elem_reg);
            end
            OP_BLOCKS:
            begin
                mul_req.a = WORD_W'(kinds_reg);
                mul_req.b = WORD_W'(pages);
            end
            OP_ALLOC:
            begin
                mul_req.a = WORD_W'(blocks_reg);
                mul_req.b = WORD_W'(blkb_reg);
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
        if (state_reg == BK_ISSUE && !(op_reg == OP_BLOCKS && div_busy))
        begin
            mul_req.start = 1'b1;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        job_next     = job_reg;
        kinds_next   = kinds_reg;
        tmp_next     = tmp_reg;
        elem_next    = elem_reg;
        blkb_next    = blkb_reg;
        logical_next = logical_reg;
        blocks_next  = blocks_reg;
        alloc_next   = alloc_reg;
        room_next    = room_reg;
        ovf_next     = ovf_reg;
        status_next  = status_reg;
        div_cnt_next = div_cnt_reg;
        div_quo_next = div_quo_reg;
        div_rem_next = div_rem_reg;
        nfo_next     = nfo_reg;
        seq_next     = seq_reg;
        q_pop        = 1'b0;

        res_valid_next   = res_valid_reg;
        res_tag_next     = res_tag_reg;
        res_status_next  = res_status_reg;
        res_base_next    = res_base_reg;
        res_epoch_next   = res_epoch_reg;
        res_tokens_next  = res_tokens_reg;
        res_blocks_next  = res_blocks_reg;
        res_blkb_next    = res_blkb_reg;
        res_logical_next = res_logical_reg;
        res_alloc_next   = res_alloc_reg;
        res_used_next    = res_used_reg;

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        if (div_busy)
        begin
            div_cnt_next = div_cnt_reg - 1'b1;
            div_quo_next = {div_quo_reg[TOTAL_W-2:0], rem_ge};
            div_rem_next = rem_ge ? REM_W'(rem_shift - {1'b0, cfg.tokens_per_page})
                                  : REM_W'(rem_shift);
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    job_next = q_data;
                    ovf_next = 1'b0;
                    if (q_data.invalid)
                    begin
                        status_next = ST_INVALID;
                        state_next  = BK_COMMIT;
                    end
                    else
                    begin
                        div_cnt_next = DIV_STEPS;
                        div_quo_next = q_data.token_total;
                        div_rem_next = '0;
                        // Layers times the two kinds, key and value.
                        kinds_next   = {cfg.layer_count, 1'b0};
                        op_next      = OP_HW;
                        state_next   = BK_ISSUE;
                    end
                end
            end
            BK_ISSUE:
            begin
                if (mul_req.start)
                begin
                    state_next = BK_WAIT;
                end
            end
            BK_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    ovf_next = ovf_reg | mul_rsp.ovf;
                    unique case (op_reg) inside
                        OP_HW, OP_TK: tmp_next     = mul_rsp.prod[TMP_W-1:0];
                        OP_ES:        elem_next    = mul_rsp.prod[ELEM_W-1:0];
                        OP_BLK:       blkb_next    = mul_rsp.prod[BLKB_W-1:0];
                        OP_LOG:       logical_next = mul_rsp.prod;
                        OP_BLOCKS:    blocks_next  = mul_rsp.prod[BLOCKS_W-1:0];
                        default:      alloc_next   = mul_rsp.prod;
                    endcase
                    if (op_reg == OP_ALLOC)
                    begin
                        state_next = BK_ROOM;
                    end
                    else
                    begin
                        op_next    = op_after;
                        state_next = BK_ISSUE;
                    end
                end
            end
            BK_ROOM:
            begin
                room_next  = (cfg.capacity > nfo_reg) ? cfg.capacity - nfo_reg : '0;
                state_next = BK_CHECK;
            end
            BK_CHECK:
            begin
                if (ovf_reg)
                begin
                    status_next = ST_OVERFLOW;
                end
                else if (alloc_reg > room_reg)
                begin
                    status_next = ST_CAPACITY;
                end
                else
                begin
                    status_next = ST_OK;
                end
                state_next = BK_COMMIT;
            end
            BK_COMMIT:
            begin
                if (out_free)
                begin
                    res_valid_next   = 1'b1;
                    res_tag_next     = job_reg.tag;
                    res_status_next  = status_reg;
                    res_base_next    = nfo_reg;
                    res_epoch_next   = is_ok ? seq_reg : '0;
                    res_tokens_next  = is_ok ? job_reg.token_total : '0;
                    res_blocks_next  = is_ok ? WORD_W'(blocks_reg) : '0;
                    res_blkb_next    = is_ok ? WORD_W'(blkb_reg) : '0;
                    res_logical_next = is_ok ? logical_reg : '0;
                    res_alloc_next   = is_ok ? alloc_reg : '0;
                    res_used_next    = is_ok ? nfo_reg + alloc_reg : nfo_reg;
                    if (is_ok)
                    begin
                        nfo_next = nfo_reg + alloc_reg;
                        seq_next = seq_reg + 1'b1;
                    end
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            div_cnt_reg   <= '0;
            nfo_reg       <= '0;
            seq_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            nfo_reg       <= nfo_next;
            seq_reg       <= seq_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        job_reg         <= job_next;
        kinds_reg       <= kinds_next;
        tmp_reg         <= tmp_next;
        elem_reg        <= elem_next;
        blkb_reg        <= blkb_next;
        logical_reg     <= logical_next;
        blocks_reg      <= blocks_next;
        alloc_reg       <= alloc_next;
        room_reg        <= room_next;
        ovf_reg         <= ovf_next;
        status_reg      <= status_next;
        div_quo_reg     <= div_quo_next;
        div_rem_reg     <= div_rem_next;
        res_tag_reg     <= res_tag_next;
        res_status_reg  <= res_status_next;
        res_base_reg    <= res_base_next;
        res_epoch_reg   <= res_epoch_next;
        res_tokens_reg  <= res_tokens_next;
        res_blocks_reg  <= res_blocks_next;
        res_blkb_reg    <= res_blkb_next;
        res_logical_reg <= res_logical_next;
        res_alloc_reg   <= res_alloc_next;
        res_used_reg    <= res_used_next;
    end

    assign res.valid           = res_valid_reg;
    assign res.tag_out         = res_tag_reg;
    assign res.status          = res_status_reg;
    assign res.base_offset     = res_base_reg;
    assign res.epoch           = res_epoch_reg;
    assign res.token_total     = res_tokens_reg;
    assign res.block_count     = res_blocks_reg;
    assign res.block_bytes     = res_blkb_reg;
    assign res.logical_bytes   = res_logical_reg;
    assign res.allocated_bytes = res_alloc_reg;
    assign res.used_total      = res_used_reg;
endmodule

// ===== hw/rtl/paged_kv_bump_allocator.sv =====
// Top level of the paged key/value cache bump allocator: configuration
// registers, front end, job queue and back end. Depends on pkba_pkg,
// pkba_req_if, pkba_res_if, pkba_front, pkba_queue and pkba_back.
//
//   Channel  Direction  Handshake           Carries
//   req      in         valid/ready         request_tag, prompt_tokens, output_tokens
//   res      out        valid/ready         tag, status, offsets, sizes, epoch
//   apb      in         psel/penable/pready 64-bit register writes and reads
//
// In the back end a valid request is dequeued, then runs seven 64 x 64 multiplies
// in turn on the shared multiplier (each an issue step, four 32 x 32 partial
// products, a last accumulate and the hand-back), then the room, check and
// commit states. The page divider runs alongside the first multiplies. An
// invalid request goes from the dequeue straight to the commit state.
// Reset (rst_n low, asynchronous) clears the offset and the epoch counter and
// loads the register defaults. Until the queue is full, the front end keeps
// accepting items into it while the back end works, and a finished result waits
// in the output register without holding up the computation of the next one.
module paged_kv_bump_allocator #(
    parameter int QUEUE_DEPTH = pkba_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    pkba_req_if.sink                      req,
    pkba_res_if.source                    res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pkba_pkg::ADDR_W-1:0]   paddr,
    input  logic [pkba_pkg::DATA_W-1:0]   pwdata,
    output logic [pkba_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import pkba_pkg::*;

    logic [WORD_W-1:0]  capacity_reg;
    logic [FIELD_W-1:0] layer_count_reg;
    logic [FIELD_W-1:0] kv_head_count_reg;
    logic [FIELD_W-1:0] head_width_reg;
    logic [SIZE_W-1:0]  element_size_reg;
    logic [FIELD_W-1:0] tokens_per_page_reg;

    cfg_t     cfg;
    reg_idx_t reg_idx;
    logic     wr_en;
    logic     q_full, q_push, q_valid, q_pop;
    job_t     q_in, q_out;

    // Registers sit on 8-byte boundaries; the low address bits are ignored.
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg        <= CAPACITY_RESET;
            layer_count_reg     <= FIELD_RESET;
            kv_head_count_reg   <= FIELD_RESET;
            head_width_reg      <= FIELD_RESET;
            element_size_reg    <= SIZE_RESET;
            tokens_per_page_reg <= TPP_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CAPACITY:        capacity_reg        <= pwdata;
                REG_LAYER_COUNT:     layer_count_reg     <= pwdata[FIELD_W-1:0];
                REG_KV_HEAD_COUNT:   kv_head_count_reg   <= pwdata[FIELD_W-1:0];
                REG_HEAD_WIDTH:      head_width_reg      <= pwdata[FIELD_W-1:0];
                REG_ELEMENT_SIZE:    element_size_reg    <= pwdata[SIZE_W-1:0];
                REG_TOKENS_PER_PAGE: tokens_per_page_reg <= pwdata[FIELD_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CAPACITY:        prdata = capacity_reg;
            REG_LAYER_COUNT:     prdata = DATA_W'(layer_count_reg);
            REG_KV_HEAD_COUNT:   prdata = DATA_W'(kv_head_count_reg);
            REG_HEAD_WIDTH:      prdata = DATA_W'(head_width_reg);
            REG_ELEMENT_SIZE:    prdata = DATA_W'(element_size_reg);
            REG_TOKENS_PER_PAGE: prdata = DATA_W'(tokens_per_page_reg);
            default:             prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.capacity        = capacity_reg;
        cfg.layer_count     = layer_count_reg;
        cfg.kv_head_count   = kv_head_count_reg;
        cfg.head_width      = head_width_reg;
        cfg.element_size    = element_size_reg;
        cfg.tokens_per_page = tokens_per_page_reg;
    end

    // Front end: classification and token total.
    pkba_front u_front (
        .cfg    (cfg),
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    // Job queue decoupling the two halves.
    pkba_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .valid     (q_valid),
        .pop       (q_pop),
        .pop_data  (q_out)
    );

    // Back end: division, multiplies, capacity check, state and result.
    pkba_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .res     (res)
    );

    // A rejected request leaves the offset where it was and carries no epoch.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status != ST_OK) |->
        (res.base_offset == res.used_total && res.epoch == '0))
        else $error("error result moved the offset or carries an epoch");

    // A granted allocation advances the offset by exactly its size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == ST_OK) |->
        (res.used_total == res.base_offset + res.allocated_bytes))
        else $error("used total does not match base plus allocation");

    // Page rounding never reserves fewer bytes than the tokens need.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == ST_OK) |->
        (res.allocated_bytes >= res.logical_bytes))
        else $error("allocated bytes below logical bytes");
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the paged key/value bump allocator: request and result
// channels with random stalls, APB register writes, and a built-in allocation predictor.
// Depends on pkba_pkg, pkba_req_if, pkba_res_if and paged_kv_bump_allocator.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pkba_pkg::*;

    // Cycles to let the back end settle after the last result.
    localparam int SETTLE_CYCLES   = 60;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_PHASES   = 16;
    localparam int ITEMS_PER_PHASE = 75;

    // K and V are counted as two separate page sets per layer.
    localparam logic [WORD_W-1:0] KV_KINDS = 64'd2;
    localparam logic [WORD_W-1:0] ALL_ONES = '1;
    // An address past the last register; writes there must change nothing.
    localparam logic [ADDR_W-1:0] SPARE_ADDR = 6'd48;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [TOK_W-1:0] prompt;
        logic [TOK_W-1:0] outlen;
    } alloc_request_t;

    typedef struct {
        logic [TAG_W-1:0]   tag;
        status_t            status;
        logic [WORD_W-1:0]  base_offset;
        logic [WORD_W-1:0]  epoch;
        logic [TOTAL_W-1:0] token_total;
        logic [WORD_W-1:0]  block_count;
        logic [WORD_W-1:0]  block_bytes;
        logic [WORD_W-1:0]  logical_bytes;
        logic [WORD_W-1:0]  allocated_bytes;
        logic [WORD_W-1:0]  used_total;
    } alloc_result_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    pkba_req_if req_ch ();
    pkba_res_if res_ch ();

    paged_kv_bump_allocator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the configuration and of the allocator state. The
    // configuration only changes while the block is idle, so the predictor
    // can read it at the moment an item is accepted.
    cfg_t              cfg_shadow;
    logic [WORD_W-1:0] alloc_cursor;
    logic [WORD_W-1:0] epoch_count;

    alloc_request_t pending_requests[$];
    alloc_result_t  expected_results[$];
    alloc_request_t staged_req;

    int  issued_count;
    int  accepted_count;
    int  error_count;
    int  cycle_count;
    int  src_idle_pct;
    int  snk_stall_pct;
    logic req_taken;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // 64 x 64 multiply that flags any product wider than 64 bits. On overflow
    // the product is dropped to zero; the final status is overflow anyway.
    function automatic logic [WORD_W-1:0] mul_guard(input logic [WORD_W-1:0] a,
                                                    input logic [WORD_W-1:0] b,
                                                    inout bit ovf);
        logic [2*WORD_W-1:0] prod;
        prod = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
        if (prod[2*WORD_W-1:WORD_W] != '0)
        begin
            ovf = 1'b1;
            return '0;
        end
        return prod[WORD_W-1:0];
    endfunction

    // Works out the result of one accepted request and advances the shadow
    // offset and epoch counter when the allocation succeeds.
    function automatic alloc_result_t predict_alloc(input alloc_request_t rq);
        alloc_result_t     r;
        bit                ovf;
        logic [WORD_W-1:0] tokens, tpp, pages, heads_x_width, elem, blk;
        logic [WORD_W-1:0] kinds, blocks, alloc, tokens_x_kinds, logical, room;
        ovf               = 1'b0;
        r.tag             = rq.tag;
        r.status          = ST_OK;
        r.base_offset     = alloc_cursor;
        r.epoch           = '0;
        r.token_total     = '0;
        r.block_count     = '0;
        r.block_bytes     = '0;
        r.logical_bytes   = '0;
        r.allocated_bytes = '0;
        if (rq.prompt == '0 || rq.outlen == '0 || cfg_shadow.layer_count == '0 ||
            cfg_shadow.kv_head_count == '0 || cfg_shadow.head_width == '0 ||
            cfg_shadow.element_size == '0 || cfg_shadow.tokens_per_page == '0)
        begin
            r.status = ST_INVALID;
        end
        else
        begin
            tokens         = 64'(rq.prompt) + 64'(rq.outlen) - 64'd1;
            tpp            = 64'(cfg_shadow.tokens_per_page);
            pages          = (tokens + tpp - 64'd1) / tpp;
            heads_x_width  = mul_guard(64'(cfg_shadow.kv_head_count),
                                       64'(cfg_shadow.head_width), ovf);
            elem           = mul_guard(heads_x_width, 64'(cfg_shadow.element_size), ovf);
            blk            = mul_guard(tpp, elem, ovf);
            kinds          = mul_guard(64'(cfg_shadow.layer_count), KV_KINDS, ovf);
            blocks         = mul_guard(kinds, pages, ovf);
            alloc          = mul_guard(blocks, blk, ovf);
            tokens_x_kinds = mul_guard(tokens, kinds, ovf);
            logical        = mul_guard(tokens_x_kinds, elem, ovf);
            room = (cfg_shadow.capacity > alloc_cursor) ? cfg_shadow.capacity - alloc_cursor
                                                         : '0;
            if (ovf)
                r.status = ST_OVERFLOW;
            else if (alloc > room)
                r.status = ST_CAPACITY;
            else
            begin
                r.epoch           = epoch_count;
                r.token_total     = tokens[TOTAL_W-1:0];
                r.block_count     = blocks;
                r.block_bytes     = blk;
                r.logical_bytes   = logical;
                r.allocated_bytes = alloc;
                epoch_count       = epoch_count + 64'd1;
                alloc_cursor      = alloc_cursor + alloc;
            end
        end
        r.used_total = alloc_cursor;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // Request driver. A new item goes out only when the channel is empty or
    // the current item was taken at the last rising edge, so valid never
    // drops while an item is waiting. The result side stalls independently.
    always @(negedge clk)
    begin
        if (rst_n && (!req_ch.valid || req_taken))
        begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                staged_req = pending_requests.pop_front();
                req_ch.valid         <= 1'b1;
                req_ch.request_tag   <= staged_req.tag;
                req_ch.prompt_tokens <= staged_req.prompt;
                req_ch.output_tokens <= staged_req.outlen;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
        res_ch.ready <= rst_n && ($urandom_range(99) >= snk_stall_pct);
    end

    // Monitor. Each accepted request is turned into an expectation at once;
    // each accepted result is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_taken <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with tag 0x%0h arrived with nothing outstanding",
                           res_ch.tag_out);
                    error_count++;
                end
                else
                begin
                    alloc_result_t want;
                    want = expected_results.pop_front();
                    check_field("tag_out", 64'(want.tag), 64'(res_ch.tag_out));
                    check_field("status", 64'(want.status), 64'(res_ch.status));
                    check_field("base_offset", want.base_offset, res_ch.base_offset);
                    check_field("epoch", want.epoch, res_ch.epoch);
                    check_field("token_total", 64'(want.token_total),
                                64'(res_ch.token_total));
                    check_field("block_count", want.block_count, res_ch.block_count);
                    check_field("block_bytes", want.block_bytes, res_ch.block_bytes);
                    check_field("logical_bytes", want.logical_bytes, res_ch.logical_bytes);
                    check_field("allocated_bytes", want.allocated_bytes,
                                res_ch.allocated_bytes);
                    check_field("used_total", want.used_total, res_ch.used_total);
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                alloc_request_t got_req;
                got_req.tag    = req_ch.request_tag;
                got_req.prompt = req_ch.prompt_tokens;
                got_req.outlen = req_ch.output_tokens;
                expected_results.push_back(predict_alloc(got_req));
                accepted_count++;
            end
            req_taken <= req_ch.valid && req_ch.ready;
        end
    end

    // Watchdog: a run that has not finished by now has hung.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // One APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes a register and mirrors it in the shadow; the narrow registers
    // keep only their low bits, whatever the upper data bits hold.
    task automatic set_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        apb_write({idx, 3'b000}, value);
        case (idx)
            REG_CAPACITY:        cfg_shadow.capacity        = value;
            REG_LAYER_COUNT:     cfg_shadow.layer_count     = value[FIELD_W-1:0];
            REG_KV_HEAD_COUNT:   cfg_shadow.kv_head_count   = value[FIELD_W-1:0];
            REG_HEAD_WIDTH:      cfg_shadow.head_width      = value[FIELD_W-1:0];
            REG_ELEMENT_SIZE:    cfg_shadow.element_size    = value[SIZE_W-1:0];
            REG_TOKENS_PER_PAGE: cfg_shadow.tokens_per_page = value[FIELD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic queue_request(input logic [TAG_W-1:0] tag, input logic [TOK_W-1:0] prompt,
                                 input logic [TOK_W-1:0] outlen);
        alloc_request_t rq;
        rq.tag    = tag;
        rq.prompt = prompt;
        rq.outlen = outlen;
        pending_requests.push_back(rq);
        issued_count++;
    endtask

    // Blocks until every queued item has been taken and answered, then lets
    // the back end settle so that a register write lands on an idle block.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (accepted_count != issued_count || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idle_profile(input int profile);
        case (profile)
            1:       begin src_idle_pct = 62; snk_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  snk_stall_pct = 62; end
            3:       begin src_idle_pct = 34; snk_stall_pct = 34; end
            default: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        endcase
    endtask

    // Random 64-bit register value, zero one time in ten so that the
    // invalid-argument path keeps turning up.
    function automatic logic [DATA_W-1:0] wide_or_zero();
        if ($urandom_range(9) == 0)
            return '0;
        return {$urandom, $urandom};
    endfunction

    // Token counts: mostly short requests that allocate, plus zeros, the
    // full 32-bit range, values up to 2^20 and values at the top of the range.
    function automatic logic [TOK_W-1:0] pick_length();
        int sel;
        sel = $urandom_range(99);
        if (sel < 6)
            return '0;
        else if (sel < 70)
            return TOK_W'($urandom_range(1, 2000));
        else if (sel < 85)
            return $urandom;
        else if (sel < 95)
            return TOK_W'($urandom_range(1, 32'h0010_0000));
        return 32'hFFFF_FFFF - TOK_W'($urandom_range(0, 3));
    endfunction

    // Picks a model shape and a capacity for one random phase. Small models
    // make most requests succeed; full-range shapes mostly overflow.
    task automatic random_config();
        int                sel;
        logic [DATA_W-1:0] cap;
        sel = $urandom_range(99);
        if (sel < 30)
        begin
            set_reg(REG_LAYER_COUNT, wide_or_zero());
            set_reg(REG_KV_HEAD_COUNT, wide_or_zero());
            set_reg(REG_HEAD_WIDTH, wide_or_zero());
            set_reg(REG_ELEMENT_SIZE, wide_or_zero());
            set_reg(REG_TOKENS_PER_PAGE, wide_or_zero());
        end
        else
        begin
            set_reg(REG_LAYER_COUNT, 64'($urandom_range(1, 4)));
            set_reg(REG_KV_HEAD_COUNT, 64'($urandom_range(1, 8)));
            set_reg(REG_HEAD_WIDTH, 64'($urandom_range(1, 128)));
            set_reg(REG_ELEMENT_SIZE, 64'($urandom_range(1, 4)));
            sel = $urandom_range(9);
            if (sel == 0)
                set_reg(REG_TOKENS_PER_PAGE, 64'd1);
            else if (sel == 1)
                set_reg(REG_TOKENS_PER_PAGE, 64'hFFFF);
            else
                set_reg(REG_TOKENS_PER_PAGE, 64'($urandom_range(1, 64)));
        end
        // A tight capacity just above the current offset makes a phase run
        // from successful allocations into capacity errors.
        sel = $urandom_range(99);
        if (sel < 45)
            cap = ALL_ONES;
        else if (sel < 65)
            cap = {$urandom, $urandom};
        else if (sel < 70)
            cap = 64'd1;
        else if (alloc_cursor > ALL_ONES - 64'h0400_0000)
            cap = ALL_ONES;
        else
            cap = alloc_cursor + 64'($urandom_range(0, 32'h0400_0000));
        set_reg(REG_CAPACITY, cap);
    endtask

    initial
    begin
        reg_idx_t field_regs[5];
        int       i;
        int       n;
        field_regs = '{REG_LAYER_COUNT, REG_KV_HEAD_COUNT, REG_HEAD_WIDTH,
                       REG_ELEMENT_SIZE, REG_TOKENS_PER_PAGE};

        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        req_ch.valid         = 1'b0;
        req_ch.request_tag   = '0;
        req_ch.prompt_tokens = '0;
        req_ch.output_tokens = '0;
        res_ch.ready         = 1'b0;
        req_taken            = 1'b0;
        issued_count         = 0;
        accepted_count       = 0;
        error_count          = 0;
        cycle_count          = 0;
        src_idle_pct         = 0;
        snk_stall_pct        = 0;

        cfg_shadow.capacity        = CAPACITY_RESET;
        cfg_shadow.layer_count     = FIELD_RESET;
        cfg_shadow.kv_head_count   = FIELD_RESET;
        cfg_shadow.head_width      = FIELD_RESET;
        cfg_shadow.element_size    = SIZE_RESET;
        cfg_shadow.tokens_per_page = TPP_RESET;
        alloc_cursor               = '0;
        epoch_count                = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: zero lengths are invalid, and a one-byte
        // capacity cannot hold even the smallest allocation.
        queue_request(16'h0000, 32'd0, 32'd5);
        queue_request(16'hFFFF, 32'd5, 32'd0);
        queue_request(16'h1234, 32'd1, 32'd1);
        wait_idle();

        // Unit-sized model, one token per page, unlimited capacity. The upper
        // data bits of the narrow registers must be dropped.
        set_reg(REG_CAPACITY, ALL_ONES);
        set_reg(REG_LAYER_COUNT, 64'hABCD_0000_0000_0001);
        set_reg(REG_KV_HEAD_COUNT, 64'hFFFF_FFFF_FFFF_0001);
        set_reg(REG_HEAD_WIDTH, 64'h0000_0001_0000_0001);
        set_reg(REG_ELEMENT_SIZE, 64'h5555_AAAA_0000_FF01);
        set_reg(REG_TOKENS_PER_PAGE, 64'd1);
        @(posedge clk);
        queue_request(16'h0001, 32'd1, 32'd1);
        queue_request(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(16'h8000, 32'h8000_0000, 32'd1);
        queue_request(16'h7FFF, 32'd1, 32'hFFFF_FFFF);
        wait_idle();

        // Room for exactly one two-byte allocation: the first fits to the
        // byte, the second is refused.
        set_reg(REG_CAPACITY, alloc_cursor + 64'd2);
        @(posedge clk);
        queue_request(16'h00A5, 32'd1, 32'd1);
        queue_request(16'h005A, 32'd1, 32'd1);
        wait_idle();

        // Capacity lowered below the running offset leaves no room at all.
        set_reg(REG_CAPACITY, alloc_cursor - 64'd1);
        @(posedge clk);
        queue_request(16'h0F0F, 32'd2, 32'd3);
        wait_idle();
        set_reg(REG_CAPACITY, 64'd0);
        @(posedge clk);
        queue_request(16'hF0F0, 32'd2, 32'd3);
        wait_idle();

        // Each model register at zero on its own makes the request invalid.
        set_reg(REG_CAPACITY, ALL_ONES);
        for (i = 0; i < 5; i++)
        begin
            set_reg(field_regs[i], 64'd0);
            @(posedge clk);
            queue_request(TAG_W'(16'h0100 + i), 32'd7, 32'd9);
            wait_idle();
            set_reg(field_regs[i], 64'd1);
        end

        // Every model register at its maximum overflows the allocated size
        // product. A write past the last register must not disturb anything.
        set_reg(REG_LAYER_COUNT, 64'hFFFF);
        set_reg(REG_KV_HEAD_COUNT, 64'hFFFF);
        set_reg(REG_HEAD_WIDTH, 64'hFFFF);
        set_reg(REG_ELEMENT_SIZE, 64'hFF);
        set_reg(REG_TOKENS_PER_PAGE, 64'hFFFF);
        apb_write(SPARE_ADDR, ALL_ONES);
        @(posedge clk);
        queue_request(16'h0200, 32'd1, 32'd1);
        queue_request(16'h0201, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();

        // Random phases: a fresh model shape and capacity each time, and the
        // idling pattern rotating through all four combinations.
        for (n = 0; n < RANDOM_PHASES; n++)
        begin
            random_config();
            set_idle_profile(n % 4);
            @(posedge clk);
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                queue_request(TAG_W'($urandom), pick_length(), pick_length());
            wait_idle();
        end

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pkba_pkg.sv
hw/rtl/pkba_if.sv
hw/rtl/pkba_front.sv
hw/rtl/pkba_queue.sv
hw/rtl/pkba_mul.sv
hw/rtl/pkba_back.sv
hw/rtl/paged_kv_bump_allocator.sv
bench/tb_top.sv
